[hw/rtl/rbox_pkg.sv]
// Shared types, constants and float helpers for the ray/box slab hit test.
package rbox_pkg;

  typedef logic [31:0] f32_t;

  localparam int unsigned NumAxes    = 3;
  localparam int unsigned NumLanes   = 2 * NumAxes;
  localparam int unsigned SubStages  = 3;
  localparam int unsigned DivStages  = 30;
  localparam int unsigned CmpStages  = 3;
  localparam int unsigned PipeStages = SubStages + DivStages + CmpStages;

  localparam f32_t QNAN         = 32'h7FC0_0000;
  localparam f32_t TSTART_RESET = 32'h3A83_126F;
  localparam f32_t TEND_RESET   = 32'h7F80_0000;

  typedef enum logic [0:0] {
    REG_T_START = 1'b0,
    REG_T_END   = 1'b1
  } reg_idx_e;

  function automatic logic f_is_nan(f32_t a);
    return (&a[30:23]) && (|a[22:0]);
  endfunction

  // IEEE a < b: false on NaN, signed zeros equal.
  function automatic logic f_lt(f32_t a, f32_t b);
    logic r;
    if (f_is_nan(a) || f_is_nan(b)) begin
      r = 1'b0;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      r = 1'b0;
    end else if (a[31] && !b[31]) begin
      r = 1'b1;
    end else if (!a[31] && b[31]) begin
      r = 1'b0;
    end else if (!a[31]) begin
      r = a[30:0] < b[30:0];
    end else begin
      r = a[30:0] > b[30:0];
    end
    return r;
  endfunction

  function automatic f32_t f_min(f32_t a, f32_t b);
    f32_t r;
    if (f_is_nan(a)) begin
      r = b;
    end else if (f_is_nan(b)) begin
      r = a;
    end else begin
      r = f_lt(b, a) ? b : a;
    end
    return r;
  endfunction

  function automatic f32_t f_max(f32_t a, f32_t b);
    f32_t r;
    if (f_is_nan(a)) begin
      r = b;
    end else if (f_is_nan(b)) begin
      r = a;
    end else begin
      r = f_lt(a, b) ? b : a;
    end
    return r;
  endfunction

  function automatic logic [4:0] lzc27(logic [26:0] v);
    logic [4:0] c;
    c = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) c = 5'(26 - i);
    end
    return c;
  endfunction

  function automatic logic [4:0] lzc24(logic [23:0] v);
    logic [4:0] c;
    c = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) c = 5'(23 - i);
    end
    return c;
  endfunction

endpackage

[hw/rtl/rbox_fsub.sv]
// Three-stage single-precision subtractor, round to nearest even.
module rbox_fsub (
  input  logic                 clk_i,
  input  logic [2:0]           en_i,
  input  rbox_pkg::f32_t       a_i,
  input  rbox_pkg::f32_t       b_i,
  output rbox_pkg::f32_t       res_o
);
  import rbox_pkg::*;

  // stage 1: classify, order by magnitude
  f32_t       bn, lg, sm;
  logic       swap, a_nan, b_nan, a_inf, b_inf;
  logic [7:0] el_e, es_e;

  logic        sgn_q, sub_q, nan_q, inf_q;
  logic [7:0]  el_q, dist_q;
  logic [23:0] ml_q, ms_q;

  always_comb begin
    bn    = {~b_i[31], b_i[30:0]};
    a_nan = f_is_nan(a_i);
    b_nan = f_is_nan(bn);
    a_inf = (&a_i[30:23]) && !(|a_i[22:0]);
    b_inf = (&bn[30:23]) && !(|bn[22:0]);
    swap  = bn[30:0] > a_i[30:0];
    lg    = swap ? bn : a_i;
    sm    = swap ? a_i : bn;
    el_e  = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
    es_e  = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sgn_q  <= lg[31];
      sub_q  <= lg[31] ^ sm[31];
      nan_q  <= a_nan | b_nan | (a_inf & b_inf & (a_i[31] ^ bn[31]));
      inf_q  <= a_inf | b_inf;
      el_q   <= el_e;
      dist_q <= el_e - es_e;
      ml_q   <= {|lg[30:23], lg[22:0]};
      ms_q   <= {|sm[30:23], sm[22:0]};
    end
  end

  // stage 2: align with sticky, add or subtract
  logic [26:0] ext, al;
  logic        st;
  logic [27:0] sum_d;

  logic        sgn2_q, sub2_q, nan2_q, inf2_q;
  logic [7:0]  el2_q;
  logic [27:0] sum_q;

  always_comb begin
    ext = {ms_q, 3'b000};
    if (dist_q >= 8'd27) begin
      al = '0;
      st = |ms_q;
    end else begin
      al = ext >> dist_q;
      st = |(ext & ~({27{1'b1}} << dist_q));
    end
    al[0] = al[0] | st;
    if (sub_q) begin
      sum_d = {1'b0, ml_q, 3'b000} - {1'b0, al};
    end else begin
      sum_d = {1'b0, ml_q, 3'b000} + {1'b0, al};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sgn2_q <= sgn_q;
      sub2_q <= sub_q;
      nan2_q <= nan_q;
      inf2_q <= inf_q;
      el2_q  <= el_q;
      sum_q  <= sum_d;
    end
  end

  // stage 3: normalise, round, pack
  logic [4:0]  lz;
  logic [7:0]  lim, sh;
  logic [26:0] m;
  logic [8:0]  e9;
  logic        rnd;
  logic [30:0] pack;
  f32_t        res_d, res_q;

  always_comb begin
    lz   = lzc27(sum_q[26:0]);
    lim  = el2_q - 8'd1;
    sh   = ({3'b000, lz} < lim) ? {3'b000, lz} : lim;
    if (sum_q[27]) begin
      m  = {sum_q[27:2], sum_q[1] | sum_q[0]};
      e9 = {1'b0, el2_q} + 9'd1;
    end else begin
      m  = sum_q[26:0] << sh;
      e9 = m[26] ? ({1'b0, el2_q} - {1'b0, sh}) : 9'd0;
    end
    rnd  = m[2] & (m[1] | m[0] | m[3]);
    pack = {e9[7:0], m[25:3]} + {30'd0, rnd};
    if (nan2_q) begin
      res_d = QNAN;
    end else if (inf2_q || (e9 >= 9'd255)) begin
      res_d = {sgn2_q, 8'hFF, 23'd0};
    end else if (sum_q == 28'd0) begin
      res_d = {sgn2_q & ~sub2_q, 31'd0};
    end else begin
      res_d = {sgn2_q, pack};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

[hw/rtl/rbox_fdiv.sv]
// Pipelined single-precision divider, one quotient bit per stage, round to nearest even.
module rbox_fdiv (
  input  logic                 clk_i,
  input  logic [29:0]          en_i,
  input  rbox_pkg::f32_t       n_i,
  input  rbox_pkg::f32_t       d_i,
  output rbox_pkg::f32_t       res_o
);
  import rbox_pkg::*;

  localparam int unsigned QBits = 27;

  typedef struct packed {
    logic signed [10:0] qe;
    logic               sgn;
    logic               nan;
    logic               inf;
    logic               zero;
  } dctl_t;

  // stage 0: unpack, normalise subnormals, specials
  logic        n_nan, d_nan, n_inf, d_inf, n_zero, d_zero;
  logic [23:0] nm, dm;
  logic [4:0]  lzn, lzd;
  logic [7:0]  ne_e, de_e;
  logic signed [10:0] en_s, ed_s;
  dctl_t       ctl0;

  always_comb begin
    n_nan  = f_is_nan(n_i);
    d_nan  = f_is_nan(d_i);
    n_inf  = (&n_i[30:23]) && !(|n_i[22:0]);
    d_inf  = (&d_i[30:23]) && !(|d_i[22:0]);
    n_zero = n_i[30:0] == 31'd0;
    d_zero = d_i[30:0] == 31'd0;
    nm     = {|n_i[30:23], n_i[22:0]};
    dm     = {|d_i[30:23], d_i[22:0]};
    lzn    = lzc24(nm);
    lzd    = lzc24(dm);
    ne_e   = (n_i[30:23] == 8'd0) ? 8'd1 : n_i[30:23];
    de_e   = (d_i[30:23] == 8'd0) ? 8'd1 : d_i[30:23];
    en_s   = $signed({3'b000, ne_e}) - $signed({6'd0, lzn});
    ed_s   = $signed({3'b000, de_e}) - $signed({6'd0, lzd});
    ctl0.qe   = en_s - ed_s + 11'sd127;
    ctl0.sgn  = n_i[31] ^ d_i[31];
    ctl0.nan  = n_nan | d_nan | (n_zero & d_zero) | (n_inf & d_inf);
    ctl0.inf  = n_inf | d_zero;
    ctl0.zero = n_zero | d_inf;
  end

  logic [24:0]      rem_q [QBits+1];
  logic [QBits-1:0] q_q   [QBits+1];
  logic [23:0]      md_q  [QBits+1];
  dctl_t            ctl_q [QBits+1];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= {1'b0, nm << lzn};
      q_q[0]   <= '0;
      md_q[0]  <= dm << lzd;
      ctl_q[0] <= ctl0;
    end
  end

  // restoring division, one stage per quotient bit
  for (genvar k = 1; k <= QBits; k++) begin : g_div
    logic        ge;
    logic [24:0] diff;
    always_comb begin
      ge   = rem_q[k-1] >= {1'b0, md_q[k-1]};
      diff = ge ? (rem_q[k-1] - {1'b0, md_q[k-1]}) : rem_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k] <= {diff[23:0], 1'b0};
        q_q[k]   <= {q_q[k-1][QBits-2:0], ge};
        md_q[k]  <= md_q[k-1];
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  // post stage 1: normalise quotient, denormalise below the exponent range
  logic [26:0]        m, m2;
  logic signed [10:0] ee, shs;
  logic               st, st2, ovf;
  logic [7:0]         fld;

  always_comb begin
    st = |rem_q[QBits];
    if (q_q[QBits][26]) begin
      m  = q_q[QBits];
      ee = ctl_q[QBits].qe;
    end else begin
      m  = {q_q[QBits][25:0], 1'b0};
      ee = ctl_q[QBits].qe - 11'sd1;
    end
    ovf = ee >= 11'sd255;
    shs = 11'sd1 - ee;
    fld = ee[7:0];
    m2  = m;
    st2 = st;
    if (ee <= 11'sd0) begin
      fld = 8'd0;
      if (shs >= 11'sd27) begin
        m2  = '0;
        st2 = st | (|m);
      end else begin
        m2  = m >> shs[4:0];
        st2 = st | (|(m & ~({27{1'b1}} << shs[4:0])));
      end
    end
  end

  logic [26:0] m_q;
  logic        st_q, ovf_q;
  logic [7:0]  fld_q;
  dctl_t       ctlp_q;

  always_ff @(posedge clk_i) begin
    if (en_i[QBits+1]) begin
      m_q    <= m2;
      st_q   <= st2;
      ovf_q  <= ovf;
      fld_q  <= fld;
      ctlp_q <= ctl_q[QBits];
    end
  end

  // post stage 2: round and pack
  logic        rnd;
  logic [30:0] pack;
  f32_t        res_d, res_q;

  always_comb begin
    rnd  = m_q[2] & (m_q[1] | m_q[0] | st_q | m_q[3]);
    pack = {fld_q, m_q[25:3]} + {30'd0, rnd};
    if (ctlp_q.nan) begin
      res_d = QNAN;
    end else if (ctlp_q.inf || ovf_q) begin
      res_d = {ctlp_q.sgn, 8'hFF, 23'd0};
    end else if (ctlp_q.zero) begin
      res_d = {ctlp_q.sgn, 31'd0};
    end else begin
      res_d = {ctlp_q.sgn, pack};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[QBits+2]) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

[hw/rtl/rbox_slab_cmp.sv]
// Interval narrowing over the three axes, one axis per stage.
module rbox_slab_cmp (
  input  logic                 clk_i,
  input  logic [2:0]           en_i,
  input  rbox_pkg::f32_t       t_start_i,
  input  rbox_pkg::f32_t       t_end_i,
  input  rbox_pkg::f32_t       t_i [rbox_pkg::NumLanes],
  output logic                 hit_o
);
  import rbox_pkg::*;

  f32_t lo0, hi0, lo1, hi1, lo2, hi2;
  f32_t lo_q, hi_q, lo1_q, hi1_q;
  f32_t ty_a_q, ty_b_q, tz_a_q, tz_b_q, tz_a1_q, tz_b1_q;
  logic miss_q, miss1_q, hit_q;

  always_comb begin
    lo0 = f_max(f_min(t_i[0], t_i[3]), t_start_i);
    hi0 = f_min(f_max(t_i[0], t_i[3]), t_end_i);
    lo1 = f_max(f_min(ty_a_q, ty_b_q), lo_q);
    hi1 = f_min(f_max(ty_a_q, ty_b_q), hi_q);
    lo2 = f_max(f_min(tz_a1_q, tz_b1_q), lo1_q);
    hi2 = f_min(f_max(tz_a1_q, tz_b1_q), hi1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      lo_q   <= lo0;
      hi_q   <= hi0;
      miss_q <= f_lt(hi0, lo0);
      ty_a_q <= t_i[1];
      ty_b_q <= t_i[4];
      tz_a_q <= t_i[2];
      tz_b_q <= t_i[5];
    end
    if (en_i[1]) begin
      lo1_q   <= lo1;
      hi1_q   <= hi1;
      miss1_q <= miss_q | f_lt(hi1, lo1);
      tz_a1_q <= tz_a_q;
      tz_b1_q <= tz_b_q;
    end
    if (en_i[2]) begin
      hit_q <= ~(miss1_q | f_lt(hi2, lo2));
    end
  end

  assign hit_o = hit_q;

endmodule

[hw/rtl/ray_box_slab_hit_test_core.sv]
// Ray versus axis-aligned box slab hit test, top level.
//
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tdata: 12 x single
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata: hit
//  cfg       in         cfg_valid_i / cfg_ready_o       cfg_addr_i, cfg_data_i
//
// One test enters per cycle unless every stage is full and the output is stalled;
// the pipeline has 3 subtract, 30 divide and 3 interval stages.
// rst_ni clears the valid bits and loads t_start = 0.001, t_end = +inf.
// Each stage moves when its successor is empty or moving, so bubbles close up
// and input is taken while a result waits in the output register.
module ray_box_slab_hit_test_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
  input  logic [383:0]           s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // hit in bit 0, bits 7:1 zero
  output logic [7:0]             m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  rbox_pkg::reg_idx_e     cfg_addr_i,
  input  logic [31:0]            cfg_data_i
);
  import rbox_pkg::*;

  localparam int unsigned DivBase = SubStages;
  localparam int unsigned CmpBase = SubStages + DivStages;

  f32_t t_start_q, t_end_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_start_q <= TSTART_RESET;
      t_end_q   <= TEND_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_T_START: t_start_q <= cfg_data_i;
        REG_T_END:   t_end_q   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // stage enables and valid bits
  logic [PipeStages:0]   en;
  logic [PipeStages-1:0] v_q, v_d;

  assign en[PipeStages] = m_axis_tready;
  for (genvar k = 0; k < PipeStages; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end
  assign v_d = {v_q[PipeStages-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < PipeStages; k++) begin
        if (en[k]) v_q[k] <= v_d[k];
      end
    end
  end

  assign s_axis_tready = en[0];

  // hold the directions alongside the subtractors
  f32_t dir_q [SubStages][NumAxes];

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < SubStages; s++) begin
      if (en[s]) begin
        for (int a = 0; a < NumAxes; a++) begin
          dir_q[s][a] <= (s == 0) ? s_axis_tdata[32*(9+a) +: 32] : dir_q[(s == 0) ? 0 : s-1][a];
        end
      end
    end
  end

  f32_t diff [NumLanes];
  f32_t tq   [NumLanes];

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    rbox_fsub u_sub (
      .clk_i (clk_i),
      .en_i  (en[SubStages-1:0]),
      .a_i   (s_axis_tdata[32*l +: 32]),
      .b_i   (s_axis_tdata[32*(6 + (l % NumAxes)) +: 32]),
      .res_o (diff[l])
    );
    rbox_fdiv u_div (
      .clk_i (clk_i),
      .en_i  (en[DivBase +: DivStages]),
      .n_i   (diff[l]),
      .d_i   (dir_q[SubStages-1][l % NumAxes]),
      .res_o (tq[l])
    );
  end

  logic hit;

  rbox_slab_cmp u_cmp (
    .clk_i     (clk_i),
    .en_i      (en[CmpBase +: CmpStages]),
    .t_start_i (t_start_q),
    .t_end_i   (t_end_q),
    .t_i       (tq),
    .hit_o     (hit)
  );

  assign m_axis_tvalid = v_q[PipeStages-1];
  assign m_axis_tdata  = {7'd0, hit};

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

  a_ready_follows_sink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  a_entry_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_q[0])
    else $error("accepted transfer lost at pipeline entry");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("waiting result dropped or changed");

endmodule

[bench/ray_box_slab_hit_test_core_tb.sv]
// Self-checking bench for the ray/box slab hit test core: float predictor, random streams.
`timescale 1ns / 100ps

module ray_box_slab_hit_test_core_tb;
  import rbox_pkg::*;

  localparam int unsigned LatencyCycles = PipeStages + 8;

  logic           clk_i;
  logic           rst_ni;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [383:0]   s_axis_tdata;
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  logic [7:0]     m_axis_tdata;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  reg_idx_e       cfg_addr_i;
  logic [31:0]    cfg_data_i;

  f32_t           lo_bound, hi_bound;
  logic [383:0]   pending_tests[$];
  logic           expected_hits[$];
  logic           in_took;
  int             send_gap, recv_gap, errors;
  logic           no_idle;

  ray_box_slab_hit_test_core u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_addr_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------- float helpers ----------------
  function automatic real to_real(f32_t a);
    real r;
    if (a[30:23] == 8'hFF) begin
      r = $bitstoreal({a[31], 11'h7FF, a[22:0], 29'd0});
    end else if (a[30:23] == 8'd0) begin
      r = real'(a[22:0]) * 2.0 ** (-149);
      if (a[31]) r = -r;
    end else begin
      r = $bitstoreal({a[31], 11'(a[30:23] + 11'd896), a[22:0], 29'd0});
    end
    return r;
  endfunction

  // Round a double to single, nearest-even, subnormals included.
  function automatic f32_t to_single(real r);
    logic [63:0] b, sig, kept;
    int          e, sh;
    logic        rbit, stk;
    b = $realtobits(r);
    if (b[62:52] == 11'h7FF) return (b[51:0] != 0) ? QNAN : {b[63], 8'hFF, 23'd0};
    if (b[62:0] == 63'd0) return {b[63], 31'd0};
    e   = int'(b[62:52]) - 1023;
    sig = {11'd0, 1'b1, b[51:0]};
    sh  = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 62) begin
      kept = 0; rbit = 0; stk = 1;
    end else begin
      kept = sig >> sh;
      rbit = sig[sh-1];
      stk  = (sig & ((64'd1 << (sh - 1)) - 1)) != 0;
    end
    if (rbit && (stk || kept[0])) kept = kept + 1;
    if (e >= -126) begin
      if (kept[24]) begin
        kept = kept >> 1;
        e++;
      end
      if (e > 127) return {b[63], 8'hFF, 23'd0};
      return {b[63], 8'(e + 127), kept[22:0]};
    end
    return {b[63], kept[30:0]};
  endfunction

  function automatic logic not_a_number(f32_t a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 0);
  endfunction

  function automatic logic [31:0] order_key(f32_t a);
    if (a[30:0] == 31'd0) return 32'h8000_0000;
    return a[31] ? ~a : {1'b1, a[30:0]};
  endfunction

  function automatic logic less_than(f32_t a, f32_t b);
    return !not_a_number(a) && !not_a_number(b) && (order_key(a) < order_key(b));
  endfunction

  function automatic f32_t lower_of(f32_t a, f32_t b);
    if (not_a_number(a)) return b;
    if (not_a_number(b)) return a;
    return less_than(b, a) ? b : a;
  endfunction

  function automatic f32_t upper_of(f32_t a, f32_t b);
    if (not_a_number(a)) return b;
    if (not_a_number(b)) return a;
    return less_than(a, b) ? b : a;
  endfunction

  function automatic f32_t slab_time(f32_t num, f32_t dir);
    if (dir[30:0] == 31'd0) begin
      if (not_a_number(num) || num[30:0] == 31'd0) return QNAN;
      return {num[31] ^ dir[31], 8'hFF, 23'd0};
    end
    return to_single(to_real(num) / to_real(dir));
  endfunction

  function automatic logic ray_hits_box(logic [383:0] t);
    f32_t lo, hi, da, db, ta, tb;
    lo = lo_bound;
    hi = hi_bound;
    for (int ax = 0; ax < 3; ax++) begin
      da = to_single(to_real(t[32*ax +: 32]) - to_real(t[32*(ax+6) +: 32]));
      db = to_single(to_real(t[32*(ax+3) +: 32]) - to_real(t[32*(ax+6) +: 32]));
      ta = slab_time(da, t[32*(ax+9) +: 32]);
      tb = slab_time(db, t[32*(ax+9) +: 32]);
      lo = upper_of(lower_of(ta, tb), lo);
      hi = lower_of(upper_of(ta, tb), hi);
      if (less_than(hi, lo)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [383:0] test_of(f32_t mnx, f32_t mny, f32_t mnz,
                                           f32_t mxx, f32_t mxy, f32_t mxz,
                                           f32_t ox, f32_t oy, f32_t oz,
                                           f32_t dx, f32_t dy, f32_t dz);
    return {dz, dy, dx, oz, oy, ox, mxz, mxy, mxx, mnz, mny, mnx};
  endfunction

  function automatic f32_t odd_float();
    case ($urandom_range(0, 12))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return QNAN;
      5: return 32'h7F80_0001;
      6: return 32'hFFC0_0000;
      7: return 32'h7F7F_FFFF;
      8: return 32'h0000_0001;
      9: return 32'hFFFF_FFFF;
      10: return 32'h8000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic real coord();
    return (real'($urandom_range(0, 20000)) - 10000.0) / 100.0;
  endfunction

  function automatic logic [383:0] random_test();
    logic [383:0] t;
    real          c, w, o, d;
    if ($urandom_range(0, 3) == 0) begin
      for (int i = 0; i < 12; i++) t[32*i +: 32] = odd_float();
    end else begin
      for (int ax = 0; ax < 3; ax++) begin
        c = coord();
        w = real'($urandom_range(1, 5000)) / 100.0;
        o = coord();
        if ($urandom_range(0, 1)) d = (c - o) * real'($urandom_range(50, 150)) / 100.0;
        else d = coord();
        if ($urandom_range(0, 9) == 0) d = 0.0;
        t[32*ax +: 32]     = to_single(c - w);
        t[32*(ax+3) +: 32] = to_single(c + w);
        t[32*(ax+6) +: 32] = to_single(o);
        t[32*(ax+9) +: 32] = to_single(d);
        if (d == 0.0 && $urandom_range(0, 1)) t[32*(ax+9) + 31] = 1'b1;
        if ($urandom_range(0, 15) == 0) t[32*($urandom_range(0, 3)*3+ax) +: 32] = odd_float();
      end
    end
    return t;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic write_reg(reg_idx_e idx, f32_t val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_T_START) lo_bound = val;
    else hi_bound = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_tests.size() != 0 || s_axis_tvalid || expected_hits.size() != 0)
      @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  // ---------------- driver and monitor ----------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 199) == 0) no_idle <= ~no_idle;
      if (!s_axis_tvalid || in_took) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_tests.size() != 0) begin
          s_axis_tdata  <= pending_tests.pop_front();
          s_axis_tvalid <= 1'b1;
          send_gap      <= pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap      <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap      <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    in_took <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      expected_hits.push_back(ray_hits_box(s_axis_tdata));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else if (m_axis_tdata !== {7'd0, expected_hits[0]}) begin
        report_mismatch($sformatf("tdata %h, expected hit %0b", m_axis_tdata,
                                  expected_hits[0]));
        void'(expected_hits.pop_front());
      end else begin
        void'(expected_hits.pop_front());
      end
    end
  end

  // ---------------- sequence ----------------
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = REG_T_START;
    cfg_data_i    = '0;
    in_took       = 1'b0;
    send_gap      = 0;
    recv_gap      = 0;
    errors        = 0;
    no_idle       = 1'b0;
    lo_bound      = TSTART_RESET;
    hi_bound      = TEND_RESET;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // plain hit, miss, box behind the ray, inverted box
    pending_tests.push_back(test_of(32'hBF800000, 32'hBF800000, 32'hBF800000,
      32'h3F800000, 32'h3F800000, 32'h3F800000, 32'hC0A00000, 0, 0, 32'h3F800000, 0, 0));
    pending_tests.push_back(test_of(32'hBF800000, 32'hBF800000, 32'hBF800000,
      32'h3F800000, 32'h3F800000, 32'h3F800000, 32'hC0A00000, 32'h40A00000, 0,
      32'h3F800000, 0, 0));
    pending_tests.push_back(test_of(32'hBF800000, 32'hBF800000, 32'hBF800000,
      32'h3F800000, 32'h3F800000, 32'h3F800000, 32'h40A00000, 0, 0, 32'h3F800000, 0, 0));
    pending_tests.push_back(test_of(32'h3F800000, 32'h3F800000, 32'h3F800000,
      32'hBF800000, 32'hBF800000, 32'hBF800000, 32'hC0A00000, 0, 0, 32'h3F800000,
      32'h3F000000, 32'hBF000000));
    // zero direction inside and outside the slab, origin on a face (0/0)
    pending_tests.push_back(test_of(32'hBF800000, 32'hBF800000, 32'hBF800000,
      32'h3F800000, 32'h3F800000, 32'h3F800000, 32'hC0A00000, 0, 0, 32'h3F800000,
      32'h80000000, 0));
    pending_tests.push_back(test_of(32'hBF800000, 32'hBF800000, 32'hBF800000,
      32'h3F800000, 32'h3F800000, 32'h3F800000, 32'hC0A00000, 32'h40000000, 0,
      32'h3F800000, 0, 0));
    pending_tests.push_back(test_of(32'hBF800000, 32'hBF800000, 32'hBF800000,
      32'h3F800000, 32'h3F800000, 32'h3F800000, 32'hC0A00000, 32'h3F800000, 0,
      32'h3F800000, 0, 32'h80000000));
    // all-same field patterns (zeros, ones, NaN, infinities, extremes, subnormals), then mixed specials
    pending_tests.push_back('0);
    pending_tests.push_back({384{1'b1}});
    pending_tests.push_back({12{QNAN}});
    pending_tests.push_back({12{32'h7F800000}});
    pending_tests.push_back({12{32'hFF800000}});
    pending_tests.push_back({12{32'h7F7FFFFF}});
    pending_tests.push_back({12{32'h00000001}});
    pending_tests.push_back({12{32'h80000000}});
    pending_tests.push_back(test_of(0, 0, 0, 32'h7F7FFFFF, 32'h7F7FFFFF, 32'h7F7FFFFF,
      32'hFF7FFFFF, 0, 0, 32'h00000001, 32'h7F7FFFFF, 32'h80000001));
    pending_tests.push_back(test_of(QNAN, 0, 0, QNAN, 32'h3F800000, 32'h3F800000,
      0, QNAN, 32'h3F000000, 32'h3F800000, QNAN, 32'h7F800000));
    for (int i = 0; i < 250; i++) pending_tests.push_back(random_test());
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_T_START, 32'h0000_0000); write_reg(REG_T_END, TEND_RESET); end
        1: begin write_reg(REG_T_START, 32'hFF80_0000); write_reg(REG_T_END, 32'h7F80_0000); end
        2: begin write_reg(REG_T_START, 32'h3F80_0000); write_reg(REG_T_END, 32'h4000_0000); end
        3: begin write_reg(REG_T_START, 32'hFFFF_FFFF); write_reg(REG_T_END, 32'h0000_0000); end
        default: begin
          write_reg(REG_T_END, 32'hFFFF_FFFF);
          write_reg(REG_T_START, 32'h7FFF_FFFF);
        end
      endcase
      for (int i = 0; i < 250; i++) pending_tests.push_back(random_test());
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
